[hw/rtl/bit_packer_with_crc8_crc16_defines.svh]
`ifndef BIT_PACKER_WITH_CRC8_CRC16_DEFINES_SVH
`define BIT_PACKER_WITH_CRC8_CRC16_DEFINES_SVH

// condition checked in the same cycle as the trigger
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition checked in the cycle after the trigger
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bpc_pkg.sv]
package bpc_pkg;

    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam int OPCODE_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 6;
    localparam int BYTE_W     = 8;
    localparam int PEND_W     = 7;
    localparam int REM_W      = 3;
    localparam int CRC8_W     = 8;
    localparam int CRC16_W    = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    localparam logic [CRC8_W-1:0]  CRC8_POLY  = 8'h07;
    localparam logic [CRC16_W-1:0] CRC16_POLY = 16'h8005;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_ALIGN  = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // msb-first crc-8, one byte in eight bit steps
    function automatic logic [CRC8_W-1:0] crc8_byte(input logic [CRC8_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC8_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c[CRC8_W-1] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        end
        return c;
    endfunction

    // msb-first crc-16, data enters at the top byte
    function automatic logic [CRC16_W-1:0] crc16_byte(input logic [CRC16_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
        logic [CRC16_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = c[CRC16_W-1] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[hw/rtl/bpc_queue.sv]
module bpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       wr_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       rd_data,
    output bpc_pkg::queue_status_t qstat
);
    import bpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data     = mem_reg[rd_ptr_reg];
    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);

endmodule

[hw/rtl/bpc_front.sv]
module bpc_front #(
    parameter int MAX_FIELD_BITS = bpc_pkg::MAX_FIELD_BITS_DEF,
    localparam int MAX_BYTES = (MAX_FIELD_BITS + 7) / 8,
    localparam int NB_W = $clog2(MAX_BYTES + 1),
    localparam int CMD_W = MAX_BYTES * bpc_pkg::BYTE_W + NB_W + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [bpc_pkg::OPCODE_W-1:0]   s_tuser,
    input  bpc_pkg::queue_status_t         qstat,
    output logic                           push,
    output logic [CMD_W-1:0]               cmd
);
    import bpc_pkg::*;

    localparam int BUF_W  = MAX_FIELD_BITS + PEND_W;
    localparam int CALC_W = (BUF_W > VALUE_W) ? BUF_W : VALUE_W;
    localparam int WORD_W = MAX_BYTES * BYTE_W;
    localparam int SUM_W  = $clog2(BUF_W + 1);

    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [REM_W-1:0]   pcnt_reg, pcnt_next;

    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  n;
    logic                accept;
    logic                go;
    logic                is_clear;
    logic [COUNT_W-1:0]  eff_n;
    logic [VALUE_W-1:0]  eff_val;
    logic [CALC_W-1:0]   buf_w;
    logic [SUM_W-1:0]    total;
    logic [REM_W-1:0]    rem;
    logic [NB_W-1:0]     nb;
    logic [WORD_W-1:0]   word;

    assign opcode = s_tuser;
    assign value  = s_tdata[VALUE_W-1:0];
    assign n      = s_tdata[VALUE_W +: COUNT_W];

    // classify the item into a field length and value, or a crc clear
    always_comb
    begin
        go       = 1'b0;
        is_clear = 1'b0;
        eff_n    = '0;
        eff_val  = '0;
        unique case (opcode)
            OP_APPEND:
            begin
                if (n != '0 && n <= COUNT_W'(MAX_FIELD_BITS))
                begin
                    go      = 1'b1;
                    eff_n   = n;
                    eff_val = value;
                end
            end
            OP_ALIGN:
            begin
                if (pcnt_reg != '0)
                begin
                    go    = 1'b1;
                    eff_n = COUNT_W'(BYTE_W) - COUNT_W'(pcnt_reg);
                end
            end
            OP_CLEAR:
            begin
                is_clear = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        buf_w = (CALC_W'(pend_reg) << eff_n)
              | (CALC_W'(eff_val) & ((CALC_W'(1) << eff_n) - CALC_W'(1)));
        total = SUM_W'(pcnt_reg) + SUM_W'(eff_n);
        rem   = total[REM_W-1:0];
        nb    = NB_W'(total >> REM_W);
        // completed bytes, first one in the highest byte lane in use
        word  = WORD_W'(buf_w >> rem);
    end

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && ((go && nb != '0) || is_clear);
    assign cmd      = {word, nb, is_clear};

    always_comb
    begin
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        if (accept && go)
        begin
            pend_next = buf_w[PEND_W-1:0] & ((PEND_W'(1) << rem) - PEND_W'(1));
            pcnt_next = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

endmodule

[hw/rtl/bpc_back.sv]
module bpc_back #(
    parameter int MAX_FIELD_BITS = bpc_pkg::MAX_FIELD_BITS_DEF,
    localparam int MAX_BYTES = (MAX_FIELD_BITS + 7) / 8,
    localparam int NB_W = $clog2(MAX_BYTES + 1),
    localparam int CMD_W = MAX_BYTES * bpc_pkg::BYTE_W + NB_W + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bpc_pkg::queue_status_t         qstat,
    input  logic [CMD_W-1:0]               cmd,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import bpc_pkg::*;

    localparam int WORD_W = MAX_BYTES * BYTE_W;
    localparam int IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    back_state_t state_reg, state_next;

    logic [MAX_BYTES-1:0][BYTE_W-1:0] word_reg, word_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [CRC8_W-1:0]                crc8_reg, crc8_next;
    logic [CRC16_W-1:0]               crc16_reg, crc16_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]            m_tdata_reg, m_tdata_next;
    logic                             m_tlast_reg, m_tlast_next;

    logic                  cmd_clear;
    logic [NB_W-1:0]       cmd_nb;
    logic [WORD_W-1:0]     cmd_word;
    logic                  out_free;
    logic                  emit;
    logic                  last_byte;
    logic [BYTE_W-1:0]     cur_byte;
    logic [CRC8_W-1:0]     crc8_new;
    logic [CRC16_W-1:0]    crc16_new;

    assign cmd_clear = cmd[0];
    assign cmd_nb    = cmd[NB_W:1];
    assign cmd_word  = cmd[CMD_W-1 -: WORD_W];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_byte = (idx_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty && !cmd_clear)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free && last_byte)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop  = !qstat.empty;
            BK_EMIT: emit = out_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cur_byte  = word_reg[idx_reg];
        crc8_new  = crc8_byte(crc8_reg, cur_byte);
        crc16_new = crc16_byte(crc16_reg, cur_byte);

        word_next     = word_reg;
        idx_next      = idx_reg;
        crc8_next     = crc8_reg;
        crc16_next    = crc16_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (pop)
        begin
            if (cmd_clear)
            begin
                crc8_next  = '0;
                crc16_next = '0;
            end
            else
            begin
                word_next = cmd_word;
                idx_next  = IDX_W'(cmd_nb - 1'b1);
            end
        end

        if (emit)
        begin
            crc8_next     = crc8_new;
            crc16_next    = crc16_new;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {crc16_new, crc8_new, cur_byte};
            m_tlast_next  = last_byte;
            idx_next      = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            crc8_reg     <= '0;
            crc16_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            crc8_reg     <= crc8_next;
            crc16_reg    <= crc16_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[hw/rtl/bit_packer_with_crc8_crc16.sv]
// channel   dir  tdata (low bit up)                        side band
// s_        in   field_value[31:0], bit_count[37:32]       tuser = opcode
// m_        out  out_byte[7:0], crc8_after[15:8],          tlast = last
//                crc16_after[31:16]
//
// the front takes one item per cycle while the two-entry command queue has room
// each queued command is popped in the idle state, then the back emits the k bytes it completes
// (0 to 4 at 32-bit fields), one output byte and its crc step per cycle unless the output register is held
// reset clears the pending bits, both crcs, the queue and the output valid flag
// a low m_tready holds the output register; the queue lets the front run ahead

`include "bit_packer_with_crc8_crc16_defines.svh"

module bit_packer_with_crc8_crc16 #(
    parameter int MAX_FIELD_BITS = bpc_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]  s_tdata,   // field_value, bit_count
    input  logic [bpc_pkg::OPCODE_W-1:0]   s_tuser,   // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata,   // out_byte, crc8_after, crc16_after
    output logic                           m_tlast
);
    import bpc_pkg::*;

    localparam int MAX_BYTES = (MAX_FIELD_BITS + 7) / 8;
    localparam int NB_W      = $clog2(MAX_BYTES + 1);
    localparam int CMD_W     = MAX_BYTES * BYTE_W + NB_W + 1;

    queue_status_t    qstat;
    logic             push;
    logic             pop;
    logic [CMD_W-1:0] cmd_in;
    logic [CMD_W-1:0] cmd_out;

    bpc_front #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat),
        .push     (push),
        .cmd      (cmd_in)
    );

    bpc_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .pop     (pop),
        .rd_data (cmd_out),
        .qstat   (qstat)
    );

    bpc_back #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .cmd      (cmd_out),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `BPC_ASSERT_NOW(a_no_push_when_full, push, !qstat.full, "command pushed into full queue")
    `BPC_ASSERT_NOW(a_no_pop_when_empty, pop, !qstat.empty, "command popped from empty queue")
    `BPC_ASSERT_NEXT(a_push_fills_queue, push && qstat.empty, !qstat.empty, "pushed command lost")

endmodule
